>>> rtl/flow_table_lookup_insert_evict_macros.svh
// ---------------------------------------------------------------------------
// Flow table assertion macros
// Immediate-consequence and next-cycle property checks, with an empty
// variant when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef FLOW_TABLE_LOOKUP_INSERT_EVICT_MACROS_SVH
`define FLOW_TABLE_LOOKUP_INSERT_EVICT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent holds in the same cycle as the antecedent.
`define FTLIE_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flow table assertion failed");
// The consequent holds in the cycle after the antecedent.
`define FTLIE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flow table assertion failed");
`else
`define FTLIE_ASSERT_IMPL(name, clk, rst, ante, cons)
`define FTLIE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> rtl/ftlie_pkg.sv
// ---------------------------------------------------------------------------
// Flow table package
// Table geometry, field widths, result codes, register indexes and the
// bucket hash.
// ---------------------------------------------------------------------------
package ftlie_pkg;

  // Table geometry. BUCKETS and WAYS are powers of two.
  localparam int BUCKETS    = 1024;
  localparam int WAYS       = 4;
  localparam int SLOTS      = BUCKETS * WAYS;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int WAY_W      = $clog2(WAYS);
  localparam int SLOT_W     = BKT_W + WAY_W;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int SCAN_W     = $clog2(WAYS + 1);
  localparam int PORT_SHIFT = 16;

  // Entry layout: {addresses, ports, stamp}.
  localparam int ADDR_W  = 64;
  localparam int PORTS_W = 32;
  localparam int STAMP_W = 32;
  localparam int KEY_W   = ADDR_W + PORTS_W;
  localparam int ENTRY_W = KEY_W + STAMP_W;

  // Stream widths.
  localparam int IN_W     = 128;
  localparam int OUT_USED = 2 + SLOT_W + CNT_W;
  localparam int OUT_W    = 32;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 32;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOWS    = 8'd1;
  localparam logic [STAMP_W-1:0]   IDLE_TIMEOUT_RST = 32'd300;
  localparam logic [CNT_W-1:0]     MAX_FLOWS_RST    = 13'd4096;

  // Result status codes.
  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_EVICT  = 2'd2;
  localparam logic [1:0] ST_DROP   = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [BKT_W-1:0]  bucket_t;

  // XOR hash of the tuple, reduced modulo the bucket count by a mask.
  function automatic bucket_t bucket_of(input logic [31:0] sa, input logic [31:0] da,
                                        input logic [15:0] sp, input logic [15:0] dp);
    logic [31:0] mix;
    mix = sa ^ da ^ ({16'h0000, sp} << PORT_SHIFT) ^ {16'h0000, dp};
    return mix[BKT_W-1:0];
  endfunction

endpackage

>>> rtl/ftlie_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module ftlie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/flow_table_lookup_insert_evict.sv
// ---------------------------------------------------------------------------
// Flow table lookup, insert and evict
// Hashes a packet 4-tuple to a bucket, scans the bucket's ways with one
// shared compare unit, then refreshes, inserts, evicts or drops.
// ---------------------------------------------------------------------------
// An accepted item passes the scan, decide and write states; the result is
// registered on write-back. A new item is taken only in the idle state, and
// the way scan reads one entry per cycle from the entry RAM's single read port.
// Reset: synchronous; a clearing pass (one bucket row per cycle) zeroes the
// valid bits, and no item is accepted until it finishes.
// Configuration writes are taken at any time.
`include "flow_table_lookup_insert_evict_macros.svh"

module flow_table_lookup_insert_evict (
  input  logic                             clk,
  input  logic                             rst,
  // Input item: source_address, dest_address, source_port, dest_port,
  // now_seconds (lowest bit first).
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ftlie_pkg::IN_W-1:0]       s_tdata,
  // Result item: status, slot_index, flow_count, zero fill (lowest bit first).
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ftlie_pkg::OUT_W-1:0]      m_tdata,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ftlie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftlie_pkg::CFG_W-1:0]      cfg_data
);

  import ftlie_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;

  logic [2:0]          state;
  bucket_t             clr_idx;
  logic [SCAN_W-1:0]   scan_cnt;

  logic [ADDR_W-1:0]   addrs;
  logic [PORTS_W-1:0]  ports;
  logic [STAMP_W-1:0]  now_q;
  bucket_t             bucket;

  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic                have;
  logic [WAY_W-1:0]    old_way;
  logic [STAMP_W-1:0]  old_stamp;
  logic                evict;

  logic [STAMP_W-1:0]  idle_timeout;
  logic [CNT_W-1:0]    max_flows;
  logic [CNT_W-1:0]    valid_count;

  logic                out_valid;
  logic [1:0]          out_status;
  slot_t               out_slot;
  logic [CNT_W-1:0]    out_count;

  // RAM ports.
  logic                d_we, d_re;
  slot_t               d_waddr, d_raddr;
  logic [ENTRY_W-1:0]  d_wdata, d_rdata;
  logic                v_we, v_re;
  bucket_t             v_waddr;
  logic [WAYS-1:0]     v_wdata, row;

  // Scan and write-back signals.
  logic                accept;
  logic                proc;
  logic [WAY_W-1:0]    proc_way;
  logic                proc_valid;
  logic                key_match;
  logic [STAMP_W-1:0]  proc_stamp;
  logic                older;
  logic [STAMP_W-1:0]  limit;
  logic [WAYS-1:0]     evict_mask, row_after;
  logic                free_any;
  logic [WAY_W-1:0]    free_way;
  logic                do_write;
  logic                do_insert;
  logic [CNT_W-1:0]    count_next;

  ftlie_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  ftlie_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (bucket),
    .rdata (row)
  );

  // Handshakes.
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(OUT_W - OUT_USED){1'b0}}, out_count, out_slot, out_status};

  // Scan reads: one entry per cycle, the valid row once at the start.
  assign d_re       = (state == S_SCAN) && (scan_cnt < SCAN_W'(WAYS));
  assign d_raddr    = {bucket, scan_cnt[WAY_W-1:0]};
  assign v_re       = (state == S_SCAN) && (scan_cnt == '0);

  // Shared compare unit for the way whose data arrived this cycle.
  assign proc       = (state == S_SCAN) && (scan_cnt != '0);
  assign proc_way   = WAY_W'(scan_cnt - SCAN_W'(1));
  assign proc_valid = row[proc_way];
  assign proc_stamp = d_rdata[STAMP_W-1:0];
  assign key_match  = (d_rdata[ENTRY_W-1:STAMP_W] == {addrs, ports});
  assign older      = !have || (proc_stamp < old_stamp);

  // Expiry limit with wrap.
  assign limit = now_q - idle_timeout;

  // Free way after a possible eviction, lowest way first.
  assign evict_mask = evict ? (WAYS'(1) << old_way) : '0;
  assign row_after  = row & ~evict_mask;

  always_comb begin
    free_any = 1'b0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row_after[i]) begin
        free_any = 1'b1;
        free_way = WAY_W'(i);
      end
    end
  end

  // Write-back happens once the result register can take the item.
  assign do_write   = (state == S_WRITE) && (!out_valid || m_tready);
  assign do_insert  = do_write && !hit && free_any;
  assign count_next = valid_count + CNT_W'(1) - CNT_W'(evict);

  assign d_we    = do_write && (hit || free_any);
  assign d_waddr = {bucket, hit ? hit_way : free_way};
  assign d_wdata = {addrs, ports, now_q};

  // The valid RAM is swept to zero after reset, then updated on insert.
  assign v_we    = (state == S_CLEAR) || do_insert;
  assign v_waddr = (state == S_CLEAR) ? clr_idx : bucket;
  assign v_wdata = (state == S_CLEAR) ? '0 : (row_after | (WAYS'(1) << free_way));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      scan_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + BKT_W'(1);
          if (clr_idx == BKT_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_cnt == SCAN_W'(WAYS)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (do_write) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      addrs  <= s_tdata[63:0] << 32 | {32'h0, s_tdata[63:32]};
      ports  <= {s_tdata[79:64], s_tdata[95:80]};
      now_q  <= s_tdata[127:96];
      bucket <= bucket_of(s_tdata[31:0], s_tdata[63:32], s_tdata[79:64], s_tdata[95:80]);
    end
  end

  // Hit and oldest-entry tracking over the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit  <= 1'b0;
      have <= 1'b0;
    end else if (accept) begin
      hit  <= 1'b0;
      have <= 1'b0;
    end else if (proc && proc_valid) begin
      if (key_match && !hit) begin
        hit <= 1'b1;
      end
      if (older) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && proc_valid) begin
      if (key_match && !hit) begin
        hit_way <= proc_way;
      end
      if (older) begin
        old_way   <= proc_way;
        old_stamp <= proc_stamp;
      end
    end
  end

  // Eviction decision on a miss at or above the flow limit.
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      evict <= !hit && (valid_count >= max_flows) && have && (old_stamp < limit);
    end
  end

  // Flow count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
    end else if (do_insert) begin
      valid_count <= count_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
      max_flows    <= MAX_FLOWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IDLE_TIMEOUT) begin
        idle_timeout <= cfg_data;
      end else if (cfg_index == REG_MAX_FLOWS) begin
        max_flows <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_write) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      if (hit) begin
        out_status <= ST_HIT;
        out_slot   <= {bucket, hit_way};
        out_count  <= valid_count;
      end else if (free_any) begin
        out_status <= evict ? ST_EVICT : ST_INSERT;
        out_slot   <= {bucket, free_way};
        out_count  <= count_next;
      end else begin
        out_status <= ST_DROP;
        out_slot   <= '0;
        out_count  <= valid_count;
      end
    end
  end

  // Checks.
  `FTLIE_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `FTLIE_ASSERT_IMPL(a_count_bounded, clk, rst, 1'b1, valid_count <= CNT_W'(SLOTS))
  `FTLIE_ASSERT_IMPL(a_evict_only_on_miss, clk, rst, state == S_WRITE && evict, !hit)
  `FTLIE_ASSERT_IMPL(a_scan_bounded, clk, rst, state == S_SCAN, scan_cnt <= SCAN_W'(WAYS))

endmodule

>>> verif/flow_table_lookup_insert_evict_test.sv
// ----------------------------------------------------------------------------
// Flow table lookup, insert and evict: self-checking testbench
// Packets are streamed into the table under several timeout and flow-limit
// settings. A predictor keeps its own copy of the table and checks the
// status, slot and flow count of every result in order.
// ----------------------------------------------------------------------------
module flow_table_lookup_insert_evict_test;
  import ftlie_pkg::*;

  localparam int          STALL_LIMIT = 8000;
  localparam int          SETTLE      = 12;
  localparam int          POOL_MAX    = 64;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  // One packet, source address in the lowest bits.
  typedef struct packed {
    logic [31:0] now;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] daddr;
    logic [31:0] saddr;
  } packet_t;

  // One lookup result, status in the lowest bits.
  typedef struct packed {
    logic [OUT_W-OUT_USED-1:0] pad;
    logic [CNT_W-1:0]          count;
    logic [SLOT_W-1:0]         slot;
    logic [1:0]                status;
  } flow_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted table contents and settings.
  bit                   tbl_valid [SLOTS];
  logic [95:0]          tbl_key [SLOTS];
  logic [31:0]          tbl_stamp [SLOTS];
  bit [CNT_W-1:0]       live_flows = '0;
  logic [31:0]          idle_tmo_cfg = IDLE_TIMEOUT_RST;
  logic [CNT_W-1:0]     max_flows_cfg = MAX_FLOWS_RST;

  // Stimulus and checking bookkeeping.
  packet_t              pending [$];
  flow_result_t         expected_results [$];
  packet_t              known_flows [$];
  logic [BKT_W-1:0]     hot_buckets [$];
  logic [31:0]          clock_s = '0;
  int                   items_issued = 0;
  int                   items_accepted = 0;
  int                   results_seen = 0;
  int                   fail_count = 0;
  int                   settings_run = 0;
  int                   status_tally [4];
  int unsigned          send_gap = 0;
  int unsigned          ready_wait = 0;
  int                   hold_req = 0;
  int                   hold_seen = 0;
  int                   idle_cycles = 0;
  bit                   calm = 1'b0;
  flow_result_t         got;
  flow_result_t         want;

  flow_table_lookup_insert_evict uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // saddr, daddr, sport, dport, now
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // status, slot, count, zero fill
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  // Lookup, refresh, evict, insert or drop on the predicted table.
  function automatic flow_result_t predict_flow(input packet_t p);
    logic [95:0]  key;
    logic [31:0]  mix;
    logic [31:0]  cutoff;
    int unsigned  base;
    int unsigned  s;
    int unsigned  oldest;
    bit           hit;
    bit           placed;
    bit           evicted;
    bit           have_old;
    flow_result_t r;
    key = {p.saddr, p.daddr, p.sport, p.dport};
    mix = p.saddr ^ p.daddr ^ {p.sport, 16'h0000} ^ {16'h0000, p.dport};
    base = (mix % BUCKETS) * WAYS;
    r = '0;
    r.status = ST_DROP;
    hit = 1'b0;
    placed = 1'b0;
    evicted = 1'b0;
    have_old = 1'b0;
    oldest = base;
    for (int w = 0; w < WAYS; w++) begin
      s = base + w;
      if (!hit && tbl_valid[s] && tbl_key[s] == key) begin
        tbl_stamp[s] = p.now;
        r.status = ST_HIT;
        r.slot = SLOT_W'(s);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      // At the flow limit the oldest entry goes if it has been idle too long.
      if (live_flows >= max_flows_cfg) begin
        for (int w = 0; w < WAYS; w++) begin
          s = base + w;
          if (tbl_valid[s] && (!have_old || tbl_stamp[s] < tbl_stamp[oldest])) begin
            oldest = s;
            have_old = 1'b1;
          end
        end
        cutoff = p.now - idle_tmo_cfg;
        if (have_old && tbl_stamp[oldest] < cutoff) begin
          tbl_valid[oldest] = 1'b0;
          if (live_flows > 0) live_flows--;
          evicted = 1'b1;
        end
      end
      for (int w = 0; w < WAYS; w++) begin
        s = base + w;
        if (!placed && !tbl_valid[s]) begin
          tbl_valid[s] = 1'b1;
          tbl_key[s] = key;
          tbl_stamp[s] = p.now;
          live_flows++;
          r.status = evicted ? ST_EVICT : ST_INSERT;
          r.slot = SLOT_W'(s);
          placed = 1'b1;
        end
      end
    end
    r.count = live_flows;
    return r;
  endfunction

  // New random tuple steered into the given bucket and kept for later hits.
  function automatic packet_t flow_in_bucket(input logic [BKT_W-1:0] bkt);
    packet_t     p;
    logic [31:0] mix;
    p = {$urandom, $urandom, $urandom, $urandom};
    mix = p.saddr ^ p.daddr ^ {p.sport, 16'h0000} ^ {16'h0000, p.dport};
    p.dport[BKT_W-1:0] = p.dport[BKT_W-1:0] ^ mix[BKT_W-1:0] ^ bkt;
    known_flows.push_back(p);
    if (known_flows.size() > POOL_MAX)
      known_flows.delete($urandom_range(0, known_flows.size() - 1));
    return p;
  endfunction

  // Mostly repeats and collisions into a few busy buckets, some noise.
  function automatic packet_t random_item(input int unsigned step_max);
    packet_t     p;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && known_flows.size() > 0)
      p = known_flows[$urandom_range(0, known_flows.size() - 1)];
    else if (roll < 85)
      p = flow_in_bucket(hot_buckets[$urandom_range(0, hot_buckets.size() - 1)]);
    else
      p = {$urandom, $urandom, $urandom, $urandom};
    clock_s = clock_s + $urandom_range(0, step_max);
    p.now = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_s;
    return p;
  endfunction

  task automatic queue_item(input packet_t p, input logic [31:0] t);
    p.now = t;
    pending.push_back(p);
    items_issued++;
  endtask

  // Wait until every queued packet has been taken and answered.
  task automatic drain();
    while (items_accepted != items_issued || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IDLE_TIMEOUT: idle_tmo_cfg = val;
      REG_MAX_FLOWS:    max_flows_cfg = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [31:0] tmo, input logic [31:0] maxf,
                           input int unsigned step_max, input int n,
                           input bit quiet, input bit long_hold, input bit mid_pause);
    write_reg(REG_IDLE_TIMEOUT, tmo);
    write_reg(REG_MAX_FLOWS, maxf);
    calm = quiet;
    hot_buckets.delete();
    hot_buckets.push_back('0);
    hot_buckets.push_back(BKT_W'(BUCKETS - 1));
    repeat (4) hot_buckets.push_back(BKT_W'($urandom));
    if (long_hold) hold_req++;
    for (int i = 0; i < n; i++) begin
      pending.push_back(random_item(step_max));
      items_issued++;
      if (mid_pause && i == n / 2) drain();
    end
    drain();
    settings_run++;
  endtask

  // Packet driver: offers queued packets and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_flow(s_tdata));
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          s_tdata  <= pending.pop_front();
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected: %h",
                                 results_seen, m_tdata));
        end else begin
          want = expected_results.pop_front();
          status_tally[want.status]++;
          if (got.status !== want.status || got.slot !== want.slot ||
              got.count !== want.count || got.pad !== want.pad)
            note_failure($sformatf(
              "result %0d: expected status %0d slot %0d count %0d fill %0h, got %0d %0d %0d %0h",
              results_seen, want.status, want.slot, want.count, want.pad,
              got.status, got.slot, got.count, got.pad));
        end
      end
      // Long hold on request, otherwise random short stalls.
      if (ready_wait > 0) begin
        ready_wait--;
        m_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        ready_wait = $urandom_range(300, 500);
        m_tready <= 1'b0;
      end else begin
        ready_wait = pick_gap();
        m_tready <= (ready_wait == 0);
        if (ready_wait > 0) ready_wait--;
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", idle_cycles);
      $display("flow_table_lookup_insert_evict_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    packet_t zero_tuple;
    packet_t ones_tuple;
    zero_tuple = '0;
    ones_tuple = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extreme tuples, a hit, a full bucket 0 and a drop.
    queue_item(zero_tuple, 32'd0);
    queue_item(zero_tuple, 32'd5);
    queue_item(ones_tuple, 32'hFFFF_FFFF);
    repeat (3) queue_item(flow_in_bucket('0), 32'd10);
    queue_item(flow_in_bucket('0), 32'd11);
    repeat (3) queue_item(flow_in_bucket(BKT_W'(BUCKETS - 1)), 32'd20);
    drain();

    // Flow limit reached: drop with nothing expired, eviction of the oldest
    // way, insert into an empty bucket, insert past the limit, and a tie
    // between equal stamps that the lowest way wins.
    write_reg(REG_IDLE_TIMEOUT, 32'd10);
    write_reg(REG_MAX_FLOWS, 32'd1);
    queue_item(flow_in_bucket('0), 32'd12);
    queue_item(flow_in_bucket('0), 32'd16);
    queue_item(flow_in_bucket(BKT_W'(7)), 32'd16);
    queue_item(flow_in_bucket(BKT_W'(7)), 32'd17);
    queue_item(flow_in_bucket(BKT_W'(BUCKETS - 1)), 32'd100);
    queue_item(ones_tuple, 32'd101);
    drain();
    settings_run += 2;

    // Random traffic under a range of timeouts and flow limits.
    clock_s = 32'd200;
    run_phase(32'd0, 32'd1, 3, 123, 1'b0, 1'b0, 1'b0);
    run_phase(32'd20, 32'd16, 10, 123, 1'b0, 1'b1, 1'b0);
    clock_s = 32'hFFFF_FF80;
    run_phase(32'hFFFF_FFFF, 32'd40, 5, 123, 1'b1, 1'b0, 1'b0);
    run_phase(IDLE_TIMEOUT_RST, 32'(MAX_FLOWS_RST), 100, 123, 1'b0, 1'b0, 1'b1);
    run_phase($urandom_range(0, 1000), $urandom_range(1, 200), 50, 123,
              1'b0, 1'b0, 1'b0);
    run_phase(32'd1000, 32'd0, 300, 123, 1'b0, 1'b0, 1'b0);
    write_reg(REG_UNUSED, 32'h0000_0001);
    run_phase(32'd5, 32'hFFFF_E001, 4, 123, 1'b1, 1'b0, 1'b0);
    run_phase($urandom, $urandom_range(1, 4096), $urandom_range(0, 5000), 123,
              1'b0, 1'b1, 1'b0);

    $display("Covered %0d packets over %0d table settings, with long output stalls and pauses.",
             items_accepted, settings_run);
    $display("Results: %0d hits, %0d inserts, %0d evictions, %0d drops; %0d failures.",
             status_tally[ST_HIT], status_tally[ST_INSERT], status_tally[ST_EVICT],
             status_tally[ST_DROP], fail_count);
    if (fail_count == 0) begin
      $display("flow_table_lookup_insert_evict_test OK");
    end else begin
      $display("flow_table_lookup_insert_evict_test NOT OK");
    end
    $finish;
  end

endmodule
